[hdl/gwt_pkg.sv]
package gwt_pkg;

    localparam int MAX_NUMBER_CHARS = 15;
    localparam int FRACTION_DIGITS  = 4;

    localparam int NCHARS_W = 4;
    localparam int FRAC_W   = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;
    localparam int VALUE_W  = 48;
    localparam int SUM_W    = 52;
    localparam int CMD_W    = 16;

    localparam logic [VALUE_W-1:0] MAG_MAX = 48'h7FFF_FFFF_FFFF;
    localparam longint unsigned MAG_MAX_L = 64'h0000_7FFF_FFFF_FFFF;
    localparam longint unsigned SCALE_L   = 64'd10 ** FRACTION_DIGITS;
    localparam logic [CMD_W-1:0] SAT_CMD_NUMBER = 16'((MAG_MAX_L / SCALE_L) & 64'hFFFF);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_J       = 8'h4A;
    localparam logic [7:0] CH_K       = 8'h4B;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_X       = 8'h58;
    localparam logic [7:0] CH_Y       = 8'h59;
    localparam logic [7:0] CH_Z       = 8'h5A;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    localparam logic KIND_WORD     = 1'b0;
    localparam logic KIND_LINE_END = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_PAREN,
        MODE_SEMI
    } mode_t;

    typedef struct packed {
        logic                      kind;
        logic [6:0]                letter;
        logic signed [VALUE_W-1:0] value;
        logic                      line_valid;
        logic [6:0]                gm_letter;
        logic [CMD_W-1:0]          gm_number;
        logic                      last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [QCNT_W-1:0] fill;
    } queue_status_t;

    function automatic logic [19:0] pow10(input logic [2:0] k);
        logic [19:0] p;
        case (k)
            3'd0: p = 20'd1;
            3'd1: p = 20'd10;
            3'd2: p = 20'd100;
            3'd3: p = 20'd1000;
            3'd4: p = 20'd10000;
            3'd5: p = 20'd100000;
            3'd6: p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

    function automatic logic is_number_char(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT || c == CH_PLUS
            || c == CH_MINUS;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return c == CH_G || c == CH_M || c == CH_X || c == CH_Y || c == CH_Z
            || c == CH_F || c == CH_S || c == CH_T || c == CH_P || c == CH_R
            || c == CH_I || c == CH_J || c == CH_K;
    endfunction

endpackage

[hdl/gwt_char_if.sv]
interface gwt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

[hdl/gwt_result_if.sv]
interface gwt_result_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [6:0]                         letter;
    logic signed [gwt_pkg::VALUE_W-1:0] value;
    logic                               line_valid;
    logic [6:0]                         gm_letter;
    logic [gwt_pkg::CMD_W-1:0]          gm_number;
    logic                               last;

    modport source (output valid, output kind, output letter, output value,
                    output line_valid, output gm_letter, output gm_number,
                    output last, input ready);
    modport sink (input valid, input kind, input letter, input value,
                  input line_valid, input gm_letter, input gm_number,
                  input last, output ready);
endinterface

[hdl/gcode_word_tokenizer.sv]
// An accepted character waits in the input register until the queue has room for two results.
// Throughput: one character per cycle while the queue has room; a line end that closes a word
// gives two results; the four-entry queue drains one result per cycle while the sink is ready.
// Reset (rst_n, asynchronous, active low) empties the input register and the result queue
// and clears the scanner state and the held G/M command.
module gcode_word_tokenizer (
    input  logic          clk,
    input  logic          rst_n,
    gwt_char_if.sink      chars,
    gwt_result_if.source  results
);

    logic                   in_full_reg;
    logic [7:0]             ch_reg;
    logic                   step_fire;
    logic                   queue_room;
    gwt_pkg::push_t         push;
    gwt_pkg::queue_status_t queue_status;

    assign queue_room  = (queue_status.fill <= gwt_pkg::QCNT_W'(gwt_pkg::QUEUE_DEPTH - 2));
    assign step_fire   = in_full_reg && queue_room;
    assign chars.ready = !in_full_reg || step_fire;

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            ch_reg <= chars.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (chars.valid && chars.ready)
        begin
            in_full_reg <= 1'b1;
        end
        else if (step_fire)
        begin
            in_full_reg <= 1'b0;
        end
    end

    gwt_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (step_fire),
        .ch    (ch_reg),
        .push  (push)
    );

    gwt_result_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .status  (queue_status),
        .results (results)
    );

    // The queue never holds more results than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_status.fill <= gwt_pkg::QCNT_W'(gwt_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // A line-end result always closes the results of its character.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.kind == gwt_pkg::KIND_LINE_END |-> results.last)
        else $error("line-end result without last");

    // Word results carry no command report.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.kind == gwt_pkg::KIND_WORD |->
        !results.line_valid && results.gm_letter == 7'd0
        && results.gm_number == 16'd0)
        else $error("word result carries command fields");

    // Two results are only pushed when the first is a word and the second a line end.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.first.kind == gwt_pkg::KIND_WORD && !push.first.last
        && push.second.kind == gwt_pkg::KIND_LINE_END)
        else $error("bad result pair");

endmodule

[hdl/gwt_parser.sv]
module gwt_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      ch,
    output gwt_pkg::push_t  push
);

    gwt_pkg::mode_t                  mode_reg, mode_next;
    logic [7:0]                      letter_reg, letter_next;
    logic [gwt_pkg::NCHARS_W-1:0]    nchars_reg, nchars_next;
    logic                            ended_reg, ended_next;
    logic                            neg_reg, neg_next;
    logic                            point_reg, point_next;
    logic [gwt_pkg::FRAC_W-1:0]      frac_reg, frac_next;
    logic [gwt_pkg::VALUE_W-1:0]     scaled_reg, scaled_next;
    logic [gwt_pkg::CMD_W-1:0]       int_lo_reg, int_lo_next;
    logic [7:0]                      cmd_letter_reg, cmd_letter_next;
    logic [gwt_pkg::CMD_W-1:0]       cmd_number_reg, cmd_number_next;

    logic [7:0]                  c;
    logic [3:0]                  digit;
    logic [2:0]                  frac_weight_idx;
    logic [gwt_pkg::SUM_W-1:0]   int_sum;
    logic [gwt_pkg::SUM_W-1:0]   frac_sum;
    logic [gwt_pkg::VALUE_W-1:0] int_sat;
    logic [gwt_pkg::VALUE_W-1:0] frac_sat;

    always_comb
    begin
        c = ch;
        if (ch >= gwt_pkg::LOWER_A && ch <= gwt_pkg::LOWER_Z)
        begin
            c = ch - gwt_pkg::CASE_SHIFT;
        end
    end

    assign digit           = 4'(c - gwt_pkg::CH_ZERO);
    assign frac_weight_idx = 3'(gwt_pkg::FRACTION_DIGITS - 1) - 3'(frac_reg);
    assign int_sum  = gwt_pkg::SUM_W'(scaled_reg) * gwt_pkg::SUM_W'(10)
                    + gwt_pkg::SUM_W'(digit)
                    * gwt_pkg::SUM_W'(gwt_pkg::pow10(3'(gwt_pkg::FRACTION_DIGITS)));
    assign frac_sum = gwt_pkg::SUM_W'(scaled_reg)
                    + gwt_pkg::SUM_W'(digit) * gwt_pkg::SUM_W'(gwt_pkg::pow10(frac_weight_idx));
    assign int_sat  = (int_sum > gwt_pkg::SUM_W'(gwt_pkg::MAG_MAX)) ? gwt_pkg::MAG_MAX
                    : int_sum[gwt_pkg::VALUE_W-1:0];
    assign frac_sat = (frac_sum > gwt_pkg::SUM_W'(gwt_pkg::MAG_MAX)) ? gwt_pkg::MAG_MAX
                    : frac_sum[gwt_pkg::VALUE_W-1:0];

    always_comb
    begin
        logic                      handled;
        logic                      word_emit;
        logic                      eol_emit;
        logic [gwt_pkg::CMD_W-1:0] n;
        gwt_pkg::result_t          word_res;
        gwt_pkg::result_t          eol_res;

        mode_next       = mode_reg;
        letter_next     = letter_reg;
        nchars_next     = nchars_reg;
        ended_next      = ended_reg;
        neg_next        = neg_reg;
        point_next      = point_reg;
        frac_next       = frac_reg;
        scaled_next     = scaled_reg;
        int_lo_next     = int_lo_reg;
        cmd_letter_next = cmd_letter_reg;
        cmd_number_next = cmd_number_reg;
        handled   = 1'b0;
        word_emit = 1'b0;
        eol_emit  = 1'b0;
        n         = '0;
        word_res  = '0;
        eol_res   = '0;

        if (mode_reg == gwt_pkg::MODE_NUMBER)
        begin
            if (c != gwt_pkg::CH_NUL && gwt_pkg::is_number_char(c))
            begin
                handled = 1'b1;
                if (32'(nchars_reg) < gwt_pkg::MAX_NUMBER_CHARS)
                begin
                    nchars_next = nchars_reg + gwt_pkg::NCHARS_W'(1);
                    if (!ended_reg)
                    begin
                        if (c == gwt_pkg::CH_PLUS || c == gwt_pkg::CH_MINUS)
                        begin
                            if (nchars_reg == '0)
                            begin
                                neg_next = (c == gwt_pkg::CH_MINUS);
                            end
                            else
                            begin
                                ended_next = 1'b1;
                            end
                        end
                        else if (c == gwt_pkg::CH_POINT)
                        begin
                            if (point_reg)
                            begin
                                ended_next = 1'b1;
                            end
                            else
                            begin
                                point_next = 1'b1;
                            end
                        end
                        else if (point_reg)
                        begin
                            if (32'(frac_reg) < gwt_pkg::FRACTION_DIGITS)
                            begin
                                scaled_next = frac_sat;
                                frac_next   = frac_reg + gwt_pkg::FRAC_W'(1);
                            end
                        end
                        else
                        begin
                            scaled_next = int_sat;
                            int_lo_next = 16'(int_lo_reg * 16'd10 + 16'(digit));
                        end
                    end
                end
            end
            else
            begin
                if (gwt_pkg::is_word(letter_reg))
                begin
                    word_emit         = 1'b1;
                    word_res.kind     = gwt_pkg::KIND_WORD;
                    word_res.letter   = 7'(letter_reg);
                    word_res.value    = neg_reg ? -scaled_reg : scaled_reg;
                    if (letter_reg == gwt_pkg::CH_G || letter_reg == gwt_pkg::CH_M)
                    begin
                        n = (scaled_reg == gwt_pkg::MAG_MAX) ? gwt_pkg::SAT_CMD_NUMBER
                          : int_lo_reg;
                        if (neg_reg)
                        begin
                            n = -n;
                        end
                        cmd_letter_next = letter_reg;
                        cmd_number_next = n;
                    end
                end
                mode_next   = gwt_pkg::MODE_IDLE;
                letter_next = '0;
                nchars_next = '0;
                ended_next  = 1'b0;
                neg_next    = 1'b0;
                point_next  = 1'b0;
                frac_next   = '0;
                scaled_next = '0;
                int_lo_next = '0;
            end
        end

        if (!handled)
        begin
            if (c == gwt_pkg::CH_NUL)
            begin
                eol_emit           = 1'b1;
                eol_res.kind       = gwt_pkg::KIND_LINE_END;
                eol_res.line_valid = (cmd_letter_next != '0);
                eol_res.gm_letter  = 7'(cmd_letter_next);
                eol_res.gm_number  = cmd_number_next;
                eol_res.last       = 1'b1;
                mode_next       = gwt_pkg::MODE_IDLE;
                letter_next     = '0;
                nchars_next     = '0;
                ended_next      = 1'b0;
                neg_next        = 1'b0;
                point_next      = 1'b0;
                frac_next       = '0;
                scaled_next     = '0;
                int_lo_next     = '0;
                cmd_letter_next = '0;
                cmd_number_next = '0;
            end
            else if (mode_next == gwt_pkg::MODE_PAREN)
            begin
                if (c == gwt_pkg::CH_RPAREN)
                begin
                    mode_next = gwt_pkg::MODE_IDLE;
                end
            end
            else if (mode_next == gwt_pkg::MODE_SEMI)
            begin
                mode_next = gwt_pkg::MODE_SEMI;
            end
            else if (c == gwt_pkg::CH_SPACE || c == gwt_pkg::CH_TAB)
            begin
                mode_next = gwt_pkg::MODE_IDLE;
            end
            else if (c == gwt_pkg::CH_LPAREN)
            begin
                mode_next = gwt_pkg::MODE_PAREN;
            end
            else if (c == gwt_pkg::CH_SEMI)
            begin
                mode_next = gwt_pkg::MODE_SEMI;
            end
            else
            begin
                mode_next   = gwt_pkg::MODE_NUMBER;
                letter_next = c;
                nchars_next = '0;
                ended_next  = 1'b0;
                neg_next    = 1'b0;
                point_next  = 1'b0;
                frac_next   = '0;
                scaled_next = '0;
                int_lo_next = '0;
            end
        end

        word_res.last = !eol_emit;
        push.count  = fire ? (2'(word_emit) + 2'(eol_emit)) : 2'd0;
        push.first  = word_emit ? word_res : eol_res;
        push.second = eol_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= gwt_pkg::MODE_IDLE;
            letter_reg     <= '0;
            nchars_reg     <= '0;
            ended_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            point_reg      <= 1'b0;
            frac_reg       <= '0;
            scaled_reg     <= '0;
            int_lo_reg     <= '0;
            cmd_letter_reg <= '0;
            cmd_number_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            letter_reg     <= letter_next;
            nchars_reg     <= nchars_next;
            ended_reg      <= ended_next;
            neg_reg        <= neg_next;
            point_reg      <= point_next;
            frac_reg       <= frac_next;
            scaled_reg     <= scaled_next;
            int_lo_reg     <= int_lo_next;
            cmd_letter_reg <= cmd_letter_next;
            cmd_number_reg <= cmd_number_next;
        end
    end

endmodule

[hdl/gwt_result_queue.sv]
module gwt_result_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gwt_pkg::push_t         push,
    output gwt_pkg::queue_status_t status,
    gwt_result_if.source           results
);

    gwt_pkg::result_t mem [gwt_pkg::QUEUE_DEPTH];

    logic [gwt_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gwt_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gwt_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [gwt_pkg::QPTR_W-1:0] wr_ptr_plus_one;
    logic                       pop;
    gwt_pkg::result_t           head;

    assign pop             = results.valid && results.ready;
    assign head            = mem[rd_ptr_reg];
    assign wr_ptr_plus_one = wr_ptr_reg + gwt_pkg::QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + gwt_pkg::QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + gwt_pkg::QPTR_W'(pop);
        count_next  = count_reg + gwt_pkg::QCNT_W'(push.count) - gwt_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus_one] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign status.fill        = count_reg;
    assign results.valid      = (count_reg != '0);
    assign results.kind       = head.kind;
    assign results.letter     = head.letter;
    assign results.value      = head.value;
    assign results.line_valid = head.line_valid;
    assign results.gm_letter  = head.gm_letter;
    assign results.gm_number  = head.gm_number;
    assign results.last       = head.last;

endmodule
